[src/iee_pkg.sv]
package iee_pkg;

  parameter int unsigned VALUE_WIDTH_DEF = 32;

  parameter logic [7:0] CH_ZERO   = 8'h30;
  parameter logic [7:0] CH_NINE   = 8'h39;
  parameter logic [7:0] CH_PLUS   = 8'h2B;
  parameter logic [7:0] CH_MINUS  = 8'h2D;
  parameter logic [7:0] CH_TIMES  = 8'h2A;
  parameter logic [7:0] CH_DIVIDE = 8'h2F;
  parameter logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    OP_PLUS   = 2'd0,
    OP_MINUS  = 2'd1,
    OP_TIMES  = 2'd2,
    OP_DIVIDE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_CHAR = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_t;

endpackage

[src/infix_expression_evaluator.sv]
// Channel   Direction  Signals                                  Payload
// in        input      in_valid_i, in_ready_o, in_data_i        char_code, last_char
// out       output     out_valid_o, out_ready_i, out_data_o     value, status
//
// A character that does not end a number is taken in the idle state. One that does applies the
// pending operator first: + or -, or / by zero, in the apply state; * and / go on to a
// shift-add multiply and a restoring divide with a sign fix, which share one adder.
// The last character then loads the output register, and waits while that register stays
// full. Input is held off until the block is back in the idle state.
// Reset is asynchronous and active low and clears the expression state and the output valid flag.
module infix_expression_evaluator #(
  parameter int unsigned VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  iee_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output iee_pkg::out_t out_data_o
);

  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned CNT_W = $clog2(VW);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VW - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_APPLY = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_FIX   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [VW-1:0]     sum_q, sum_d;
  logic [VW-1:0]     prod_q, prod_d;
  logic [VW-1:0]     num_q, num_d;
  iee_pkg::op_e      pend_q, pend_d;
  iee_pkg::op_e      aop_q, aop_d;
  logic              seen_q, seen_d;
  logic              last_q, last_d;
  iee_pkg::status_e  err_q, err_d;
  logic              out_valid_q, out_valid_d;
  iee_pkg::out_t     out_q, out_d;

  logic [VW-1:0]     opa_q, opa_d;
  logic [VW-1:0]     opb_q, opb_d;
  logic [VW-1:0]     rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [VW:0]       alu_a, alu_b, alu_s;
  logic              alu_cin;

  logic              is_digit, is_op, is_space, seen_now;
  logic [3:0]        digit;
  logic [VW-1:0]     num_x10;
  iee_pkg::op_e      new_op;
  state_e            after_apply;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign is_digit = (in_data_i.char_code >= iee_pkg::CH_ZERO) &&
                    (in_data_i.char_code <= iee_pkg::CH_NINE);
  assign is_op    = (in_data_i.char_code == iee_pkg::CH_PLUS)  ||
                    (in_data_i.char_code == iee_pkg::CH_MINUS) ||
                    (in_data_i.char_code == iee_pkg::CH_TIMES) ||
                    (in_data_i.char_code == iee_pkg::CH_DIVIDE);
  assign is_space = (in_data_i.char_code == iee_pkg::CH_SPACE);
  assign seen_now = seen_q || is_digit;

  assign digit   = in_data_i.char_code[3:0];
  assign num_x10 = {num_q[VW-4:0], 3'b000} + {num_q[VW-2:0], 1'b0} + VW'(digit);

  assign after_apply = last_q ? S_FIN : S_IDLE;

  always_comb begin
    case (in_data_i.char_code)
      iee_pkg::CH_MINUS:  new_op = iee_pkg::OP_MINUS;
      iee_pkg::CH_TIMES:  new_op = iee_pkg::OP_TIMES;
      iee_pkg::CH_DIVIDE: new_op = iee_pkg::OP_DIVIDE;
      default:            new_op = iee_pkg::OP_PLUS;
    endcase
  end

  // The one adder that the apply, multiply, divide, sign-fix and finish steps share.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_q)
      S_APPLY, S_FIN: begin
        alu_a = {1'b0, sum_q};
        alu_b = {1'b0, prod_q};
      end
      S_MUL: begin
        alu_a = {1'b0, rem_q};
        alu_b = opb_q[0] ? {1'b0, opa_q} : '0;
      end
      S_DIV: begin
        alu_a   = {rem_q, opb_q[VW-1]};
        alu_b   = ~{1'b0, opa_q};
        alu_cin = 1'b1;
      end
      S_FIX: begin
        alu_b   = {1'b0, ~opb_q};
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_s = alu_a + alu_b + (VW + 1)'(alu_cin);

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    num_d       = num_q;
    pend_d      = pend_q;
    aop_d       = aop_q;
    seen_d      = seen_q;
    last_d      = last_q;
    err_d       = err_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = in_data_i.last_char;
          aop_d  = pend_q;
          if (is_digit) begin
            num_d  = num_x10;
            seen_d = 1'b1;
          end else if (is_op) begin
            pend_d = new_op;
          end else if (!is_space && (err_q == iee_pkg::ST_OK)) begin
            err_d = iee_pkg::ST_BAD_CHAR;
          end
          if (seen_now && (is_op || in_data_i.last_char)) begin
            state_d = S_APPLY;
          end else if (in_data_i.last_char) begin
            state_d = S_FIN;
          end
        end
      end
      S_APPLY: begin
        num_d  = '0;
        seen_d = 1'b0;
        case (aop_q)
          iee_pkg::OP_PLUS: begin
            sum_d   = alu_s[VW-1:0];
            prod_d  = num_q;
            state_d = after_apply;
          end
          iee_pkg::OP_MINUS: begin
            sum_d   = alu_s[VW-1:0];
            prod_d  = -num_q;
            state_d = after_apply;
          end
          iee_pkg::OP_TIMES: begin
            rem_d   = '0;
            opa_d   = prod_q;
            opb_d   = num_q;
            cnt_d   = CNT_MAX;
            state_d = S_MUL;
          end
          default: begin
            if (num_q == '0) begin
              prod_d  = '0;
              state_d = after_apply;
              if (err_q == iee_pkg::ST_OK) begin
                err_d = iee_pkg::ST_DIV_ZERO;
              end
            end else begin
              opa_d   = num_q[VW-1] ? -num_q : num_q;
              opb_d   = prod_q[VW-1] ? -prod_q : prod_q;
              neg_d   = num_q[VW-1] ^ prod_q[VW-1];
              rem_d   = '0;
              cnt_d   = CNT_MAX;
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        rem_d = alu_s[VW-1:0];
        opa_d = {opa_q[VW-2:0], 1'b0};
        opb_d = {1'b0, opb_q[VW-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          prod_d  = alu_s[VW-1:0];
          state_d = after_apply;
        end
      end
      S_DIV: begin
        opb_d = {opb_q[VW-2:0], ~alu_s[VW]};
        rem_d = alu_s[VW] ? alu_a[VW-1:0] : alu_s[VW-1:0];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        prod_d  = neg_q ? alu_s[VW-1:0] : opb_q;
        state_d = after_apply;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_d.value  = 32'($signed(alu_s[VW-1:0]));
          out_d.status = err_q;
          sum_d        = '0;
          prod_d       = '0;
          num_d        = '0;
          pend_d       = iee_pkg::OP_PLUS;
          seen_d       = 1'b0;
          err_d        = iee_pkg::ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      prod_q      <= '0;
      num_q       <= '0;
      pend_q      <= iee_pkg::OP_PLUS;
      aop_q       <= iee_pkg::OP_PLUS;
      seen_q      <= 1'b0;
      last_q      <= 1'b0;
      err_q       <= iee_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      num_q       <= num_d;
      pend_q      <= pend_d;
      aop_q       <= aop_d;
      seen_q      <= seen_d;
      last_q      <= last_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

endmodule

[src/iee_checker.sv]
module iee_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input iee_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input iee_pkg::out_t out_data_o
);

  logic in_xfer;
  logic in_digit;
  logic in_muldiv;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign in_digit  = (in_data_i.char_code >= iee_pkg::CH_ZERO) &&
                     (in_data_i.char_code <= iee_pkg::CH_NINE);
  assign in_muldiv = (in_data_i.char_code == iee_pkg::CH_TIMES) ||
                     (in_data_i.char_code == iee_pkg::CH_DIVIDE);

  // A pending result is held until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Output result dropped or changed while stalled.");

  // A multiply or divide right after a digit occupies the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_muldiv && $past(rst_ni) && $past(in_xfer && in_digit && !in_data_i.last_char)
    |=> !in_ready_o)
    else $error("Input accepted during a multiply or divide.");

  // A new result is loaded only from a state in which input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared without a finished expression.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == iee_pkg::ST_OK) ||
                    (out_data_o.status == iee_pkg::ST_DIV_ZERO) ||
                    (out_data_o.status == iee_pkg::ST_BAD_CHAR))
    else $error("Result carries an undefined status code.");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[sim/infix_expression_evaluator_tb.sv]
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  iee_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  iee_pkg::out_t out_data;

  iee_pkg::in_t char_backlog[$];
  iee_pkg::out_t pending_answers[$];
  logic [7:0] expr_text[$];

  logic [31:0] sum_acc;
  logic [31:0] term_acc;
  logic [31:0] number_acc;
  iee_pkg::op_e op_pending;
  logic digit_seen;
  iee_pkg::status_e expr_status;

  logic in_accepted = 1'b0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic calm;

  logic [7:0] op_chars[4] = '{iee_pkg::CH_PLUS, iee_pkg::CH_MINUS,
                              iee_pkg::CH_TIMES, iee_pkg::CH_DIVIDE};
  string corner_cases[4] = '{"2147483648/4294967295", "4294967295*4294967295+1",
                             "2147483647+1", "99999999999/-7 "};

  assign calm = (results_seen >= 50) && (results_seen < 70);

  infix_expression_evaluator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("infix_expression_evaluator: mismatch");
    $finish;
  end

  task automatic clear_expression();
    sum_acc = '0;
    term_acc = '0;
    number_acc = '0;
    op_pending = iee_pkg::OP_PLUS;
    digit_seen = 1'b0;
    expr_status = iee_pkg::ST_OK;
  endtask

  // The waiting * or / folds the number into the term; + or - starts a new term with it.
  task automatic fold_number();
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quot;
    case (op_pending)
      iee_pkg::OP_PLUS: begin
        sum_acc = sum_acc + term_acc;
        term_acc = number_acc;
      end
      iee_pkg::OP_MINUS: begin
        sum_acc = sum_acc + term_acc;
        term_acc = -number_acc;
      end
      iee_pkg::OP_TIMES: begin
        term_acc = term_acc * number_acc;
      end
      default: begin
        if (number_acc == '0) begin
          if (expr_status == iee_pkg::ST_OK) expr_status = iee_pkg::ST_DIV_ZERO;
          term_acc = '0;
        end else begin
          mag_a = term_acc[31] ? -term_acc : term_acc;
          mag_b = number_acc[31] ? -number_acc : number_acc;
          quot = mag_a / mag_b;
          term_acc = (term_acc[31] ^ number_acc[31]) ? -quot : quot;
        end
      end
    endcase
    number_acc = '0;
    digit_seen = 1'b0;
  endtask

  task automatic evaluate_char(input iee_pkg::in_t item);
    iee_pkg::out_t answer;
    if (item.char_code >= iee_pkg::CH_ZERO && item.char_code <= iee_pkg::CH_NINE) begin
      number_acc = number_acc * 32'd10 + 32'(item.char_code - iee_pkg::CH_ZERO);
      digit_seen = 1'b1;
    end else if (item.char_code inside {iee_pkg::CH_PLUS, iee_pkg::CH_MINUS,
                                        iee_pkg::CH_TIMES, iee_pkg::CH_DIVIDE}) begin
      if (digit_seen) fold_number();
      case (item.char_code)
        iee_pkg::CH_PLUS:  op_pending = iee_pkg::OP_PLUS;
        iee_pkg::CH_MINUS: op_pending = iee_pkg::OP_MINUS;
        iee_pkg::CH_TIMES: op_pending = iee_pkg::OP_TIMES;
        default:           op_pending = iee_pkg::OP_DIVIDE;
      endcase
    end else if (item.char_code != iee_pkg::CH_SPACE) begin
      if (expr_status == iee_pkg::ST_OK) expr_status = iee_pkg::ST_BAD_CHAR;
    end
    if (item.last_char) begin
      if (digit_seen) fold_number();
      answer.value = sum_acc + term_acc;
      answer.status = expr_status;
      pending_answers.push_back(answer);
      clear_expression();
    end
  endtask

  task automatic queue_expression();
    iee_pkg::in_t item;
    foreach (expr_text[i]) begin
      item.char_code = expr_text[i];
      item.last_char = (i == expr_text.size() - 1);
      char_backlog.push_back(item);
    end
    expr_text.delete();
  endtask

  task automatic queue_string(input string s);
    for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
    queue_expression();
  endtask

  task automatic add_number();
    int digits;
    digits = ($urandom_range(9) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
    repeat (digits) begin
      expr_text.push_back(iee_pkg::CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(19) == 0) expr_text.push_back(iee_pkg::CH_SPACE);
    end
  endtask

  task automatic build_random_expression();
    int pick;
    int terms;
    string s;
    pick = $urandom_range(99);
    if (pick < 72) begin
      if ($urandom_range(9) == 0) expr_text.push_back(iee_pkg::CH_MINUS);
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
        if (t > 0) begin
          expr_text.push_back(op_chars[$urandom_range(3)]);
          if ($urandom_range(19) == 0) expr_text.push_back(op_chars[$urandom_range(3)]);
        end
        if ($urandom_range(9) == 0) expr_text.push_back(iee_pkg::CH_SPACE);
        add_number();
      end
      if ($urandom_range(14) == 0) expr_text.push_back(op_chars[$urandom_range(3)]);
    end else if (pick < 82) begin
      s = corner_cases[$urandom_range(3)];
      for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(3))
          0: expr_text.push_back(8'($urandom_range(255)));
          1: expr_text.push_back(iee_pkg::CH_ZERO + 8'($urandom_range(9)));
          2: expr_text.push_back(op_chars[$urandom_range(3)]);
          default: expr_text.push_back(iee_pkg::CH_SPACE);
        endcase
      end
    end
    queue_expression();
  endtask

  initial begin
    clear_expression();
    queue_string("1 2*3");
    queue_string("-7/2");
    queue_string("9/0x");
    queue_string("+");
    queue_string("5*");
    queue_string(" ");
    expr_text.push_back(8'hFF);
    queue_expression();
    expr_text.push_back(8'h00);
    queue_expression();
    queue_string("4-3 -2");
    while (char_backlog.size() < 1150) build_random_expression();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("infix_expression_evaluator: match");
    end else begin
      $display("infix_expression_evaluator: mismatch");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_accepted)) begin
      if (char_backlog.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
        in_valid <= 1'b1;
        in_data <= char_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stops for a long stretch once, so the output fills and the input stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 20) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    iee_pkg::out_t answer;
    in_accepted <= in_valid && in_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_answers.size() == 0) begin
          $error("result transfer with no expression pending: value %0d, status %0d",
                 out_data.value, out_data.status);
          mismatches++;
        end else begin
          answer = pending_answers.pop_front();
          if (out_data.value !== answer.value) begin
            $error("value: expected %0d, actual %0d", answer.value, out_data.value);
            mismatches++;
          end
          if (out_data.status !== answer.status) begin
            $error("status: expected %0d, actual %0d", answer.status, out_data.status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) evaluate_char(in_data);
    end
  end

endmodule

[sim.f]
src/iee_pkg.sv
src/infix_expression_evaluator.sv
src/iee_checker.sv
sim/infix_expression_evaluator_tb.sv
